### design/spq_pkg.sv
// types and constants shared by the stable priority queue core
// no dependencies

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int PRIO_W      = 8;
    localparam int TAG_W       = 16;
    localparam int TOTAL_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } cell_cmd_t;

endpackage

### design/spq_cell.sv
// one cell of the sorted shifting row: holds one entry
// depends on spq_pkg

module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occ,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_after,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               after
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // at or past the insert point: empty, or strictly lower priority
    assign after = !occ || (entry_reg.prio > cmd.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.enq && after)
        begin
            if (left_after)
                entry_next = left_entry;
            else
            begin
                entry_next.prio = cmd.prio;
                entry_next.tag  = cmd.tag;
            end
        end
        else if (cmd.deq)
            entry_next = right_entry;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### design/stable_priority_queue_core.sv
// top level of the stable priority queue: count, capacity register, result register
// depends on spq_pkg and spq_cell
//
// One beat per clock: busy never rises, so start may be held high every cycle.
// Each item's result appears on the result ports in the cycle after it is taken, for
// exactly one cycle with done high; the receiver cannot stall it. The row of sixteen
// cells updates all its entries in the same cycle.

module stable_priority_queue_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [spq_pkg::PRIO_W-1:0]  task_priority,
    input  logic [spq_pkg::TAG_W-1:0]   task_tag,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [spq_pkg::CAP_W-1:0]   cfg_data,
    output logic                        done,
    output logic [1:0]                  status,
    output logic                        out_valid,
    output logic [spq_pkg::TAG_W-1:0]   out_tag,
    output logic [spq_pkg::PRIO_W-1:0]  out_priority,
    output logic [spq_pkg::TOTAL_W-1:0] entry_total
);
    import spq_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    status_t          status_reg;
    status_t          status_next;
    logic             valid_reg;
    logic             valid_next;
    entry_t           head_reg;
    entry_t           head_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    cell_cmd_t        cmd;
    entry_t           row_entry [QUEUE_DEPTH];
    logic             row_after [QUEUE_DEPTH];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign is_full  = (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                   || (CMP_W'(count_reg) >= CMP_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        cmd.enq  = accept && (opcode == OP_ENQ) && !is_full;
        cmd.deq  = accept && (opcode == OP_DEQ) && !is_empty;
        cmd.prio = task_priority;
        cmd.tag  = task_tag;
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_a;
            entry_t right_e;

            if (gi == 0)
            begin : g_head
                assign left_e = '0;
                assign left_a = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = row_entry[gi-1];
                assign left_a = row_after[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = row_entry[gi];
            end
            else
            begin : g_body
                assign right_e = row_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occ         (count_reg > CNT_W'(gi)),
                .left_entry  (left_e),
                .left_after  (left_a),
                .right_entry (right_e),
                .entry       (row_entry[gi]),
                .after       (row_after[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        valid_next  = 1'b0;
        head_next   = '0;
        if (opcode == OP_ENQ)
        begin
            if (is_full)
                status_next = ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            if (is_empty)
                status_next = ST_EMPTY;
            else
            begin
                count_next = count_reg - CNT_W'(1);
                valid_next = 1'b1;
                head_next  = row_entry[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (accept)
                count_reg <= count_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            valid_reg  <= valid_next;
            head_reg   <= head_next;
            entry_total <= TOTAL_W'(count_next);
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_valid    = valid_reg;
    assign out_tag      = head_reg.tag;
    assign out_priority = head_reg.prio;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("no result after accepted beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without accepted beat");

    a_deq_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_DEQ && !is_empty) |=> (out_valid && status == ST_DONE))
        else $error("dequeue of held entry gave no task");

endmodule
